// ----- rtl/sem_pkg.sv -----
// sem_pkg: shared constants, codes and types of the eased servo pulse generator
// used by servo_eased_move_pulse_gen_top and sem_core; depends on nothing

package sem_pkg;

    // default parameter values
    localparam int PULSE_BITS_DEF = 12;
    localparam int TIME_BITS_DEF  = 16;
    localparam int ANGLE_FRAC_DEF = 8;

    // whole-degree angle and full travel
    localparam int ANGLE_INT_W = 8;
    localparam int FULL_DEG    = 180;

    // ease fraction is Q0.16; smoothstep factor 3*2^16 - 2x needs 18 bits
    localparam int XQ_BITS  = 16;
    localparam int SMUL_B_W = XQ_BITS + 2;
    localparam int SMOOTH_K = 3 << XQ_BITS;

    // register reset values
    localparam int DEFAULT_ANGLE_RST = 90;
    localparam int PULSE_LO_RST      = 150;
    localparam int PULSE_HI_RST      = 600;
    localparam int CHANNEL_RST       = 0;

    // operation codes
    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_MOVE = 2'd1;
    localparam logic [1:0] OP_HOME = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_DEFAULT_ANGLE  = 2'd0;
    localparam logic [1:0] CFG_PULSE_LO       = 2'd1;
    localparam logic [1:0] CFG_PULSE_HI       = 2'd2;
    localparam logic [1:0] CFG_OUTPUT_CHANNEL = 2'd3;

    // status flags of one result word
    typedef struct packed {
        logic pulse_valid;
        logic out_of_range;
        logic easing_active;
    } status_t;

endpackage

// ----- rtl/servo_eased_move_pulse_gen_top.sv -----
// servo_eased_move_pulse_gen_top: config registers, output register, servo core
// depends on sem_pkg and sem_core
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------------
//  in      | in_valid / in_ready  | op, target_angle, duration_ms
//  out     | out_valid/ out_ready | pulse_valid, pulse_width, pwm_channel,
//          |                      | out_of_range, current_angle, easing_active
//  cfg     | cfg_valid/ cfg_ready | cfg_index, cfg_data
//
// a timed move, an idle tick or the unused code needs no arithmetic before its result; an
// immediate move or the last tick of an ease waits on the bit-serial divide by 180; a tick
// inside an ease first waits on the serial fraction divider and the shared serial multiplier
// one word is in work at a time; the next is taken while the last result waits in the
// output register; cfg_ready is always high, reset restores register defaults

module servo_eased_move_pulse_gen_top #(
    parameter int PULSE_BITS      = sem_pkg::PULSE_BITS_DEF,
    parameter int TIME_BITS       = sem_pkg::TIME_BITS_DEF,
    parameter int ANGLE_FRAC_BITS = sem_pkg::ANGLE_FRAC_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // input words
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            op,
    input  logic signed [16:0]    target_angle,
    input  logic [15:0]           duration_ms,
    // result words
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  pulse_valid,
    output logic [PULSE_BITS-1:0] pulse_width,
    output logic [3:0]            pwm_channel,
    output logic                  out_of_range,
    output logic [7:0]            current_angle,
    output logic                  easing_active,
    // register writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [PULSE_BITS-1:0] cfg_data
);

    import sem_pkg::*;

    logic [7:0]            default_angle_reg;
    logic [PULSE_BITS-1:0] pulse_lo_reg;
    logic [PULSE_BITS-1:0] pulse_hi_reg;
    logic [3:0]            channel_reg;

    logic                  res_valid;
    logic                  res_ready;
    status_t               res_status;
    logic [PULSE_BITS-1:0] res_pulse;
    logic [7:0]            res_angle;

    logic                  out_valid_reg;
    status_t               out_status_reg;
    logic [PULSE_BITS-1:0] out_pulse_reg;
    logic [3:0]            out_channel_reg;
    logic [7:0]            out_angle_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_angle_reg <= 8'(DEFAULT_ANGLE_RST);
            pulse_lo_reg      <= PULSE_BITS'(PULSE_LO_RST);
            pulse_hi_reg      <= PULSE_BITS'(PULSE_HI_RST);
            channel_reg       <= 4'(CHANNEL_RST);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_DEFAULT_ANGLE:  default_angle_reg <= cfg_data[7:0];
                CFG_PULSE_LO:       pulse_lo_reg      <= cfg_data;
                CFG_PULSE_HI:       pulse_hi_reg      <= cfg_data;
                CFG_OUTPUT_CHANNEL: channel_reg       <= cfg_data[3:0];
                default:            channel_reg       <= channel_reg;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // servo state and arithmetic
    sem_core #(
        .PULSE_BITS      (PULSE_BITS),
        .TIME_BITS       (TIME_BITS),
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .target_angle  (target_angle),
        .duration_ms   (duration_ms),
        .default_angle (default_angle_reg),
        .pulse_lo      (pulse_lo_reg),
        .pulse_hi      (pulse_hi_reg),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res_status    (res_status),
        .res_pulse     (res_pulse),
        .res_angle     (res_angle)
    );

    // output word register
    assign res_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_ready)
            out_valid_reg <= res_valid;
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_status_reg  <= res_status;
            out_pulse_reg   <= res_pulse;
            out_channel_reg <= channel_reg;
            out_angle_reg   <= res_angle;
        end
    end

    assign out_valid     = out_valid_reg;
    assign pulse_valid   = out_status_reg.pulse_valid;
    assign pulse_width   = out_pulse_reg;
    assign pwm_channel   = out_channel_reg;
    assign out_of_range  = out_status_reg.out_of_range;
    assign current_angle = out_angle_reg;
    assign easing_active = out_status_reg.easing_active;

endmodule

// ----- rtl/sem_sdiv.sv -----
// sem_sdiv: bit-serial restoring divider, one quotient bit per cycle
// depends on nothing; remainder seed must be below the divisor

module sem_sdiv #(
    parameter int DEN_W = 16,
    parameter int STEPS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DEN_W-1:0] rem_init,
    input  logic [STEPS-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [STEPS-1:0] quo
);

    localparam int CNT_W = $clog2(STEPS + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [STEPS-1:0] sh_reg;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             fits;

    // one restoring step: bring in the next dividend bit, try to subtract
    always_comb
    begin
        trial = {rem_reg, sh_reg[STEPS-1]};
        diff  = trial - {1'b0, den};
        fits  = (trial >= {1'b0, den});
    end

    // step counter and done strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(STEPS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // remainder and dividend/quotient shift line
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= rem_init;
            sh_reg  <= num;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            sh_reg  <= {sh_reg[STEPS-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quo  = sh_reg;

endmodule

// ----- rtl/sem_smul.sv -----
// sem_smul: bit-serial shift-add multiplier, one multiplier bit per cycle
// depends on nothing; product holds until the next start

module sem_smul #(
    parameter int A_W = 16,
    parameter int B_W = 18
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [A_W-1:0]     a,
    input  logic [B_W-1:0]     b,
    output logic               done,
    output logic [A_W+B_W-1:0] p
);

    localparam int P_W   = A_W + B_W;
    localparam int CNT_W = $clog2(B_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [A_W-1:0]   a_reg;
    logic [P_W-1:0]   p_reg;

    logic [A_W:0]     sum;

    // add the multiplicand into the upper A_W bits when the low bit is set
    always_comb
    begin
        sum = {1'b0, p_reg[P_W-1:B_W]} + (p_reg[0] ? {1'b0, a_reg} : '0);
    end

    // step counter and done strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(B_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // partial product shift register, multiplier bits drain from the bottom
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= a;
            p_reg <= {{A_W{1'b0}}, b};
        end
        else if (busy_reg)
        begin
            p_reg <= {sum, p_reg[B_W-1:1]};
        end
    end

    assign done = done_reg;
    assign p    = p_reg;

endmodule

// ----- rtl/sem_core.sv -----
// sem_core: servo state, ease sequencer and pulse arithmetic for one word
// depends on sem_pkg, sem_sdiv and sem_smul

module sem_core #(
    parameter int PULSE_BITS      = sem_pkg::PULSE_BITS_DEF,
    parameter int TIME_BITS       = sem_pkg::TIME_BITS_DEF,
    parameter int ANGLE_FRAC_BITS = sem_pkg::ANGLE_FRAC_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            op,
    input  logic signed [16:0]    target_angle,
    input  logic [15:0]           duration_ms,
    input  logic [7:0]            default_angle,
    input  logic [PULSE_BITS-1:0] pulse_lo,
    input  logic [PULSE_BITS-1:0] pulse_hi,
    output logic                  res_valid,
    input  logic                  res_ready,
    output sem_pkg::status_t      res_status,
    output logic [PULSE_BITS-1:0] res_pulse,
    output logic [7:0]            res_angle
);

    import sem_pkg::*;

    localparam int TGT_W   = ANGLE_FRAC_BITS + ANGLE_INT_W;
    localparam int CL_W    = TGT_W + 10;
    localparam int SPAN_W  = PULSE_BITS + 1;
    localparam int PROD_W  = PULSE_BITS + ANGLE_INT_W;
    localparam int MUL_A_W = (TGT_W > XQ_BITS) ? TGT_W : XQ_BITS;
    localparam int MUL_B_W = SMUL_B_W;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int VAL_W   = TGT_W + XQ_BITS + 1;
    localparam int VAL_SH  = ANGLE_FRAC_BITS + XQ_BITS;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_DIVX  = 8'b0000_0010,
        ST_SQ    = 8'b0000_0100,
        ST_SS    = 8'b0000_1000,
        ST_SV    = 8'b0001_0000,
        ST_APPLY = 8'b0010_0000,
        ST_DIVP  = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } state_t;

    state_t                  state_reg, state_next;
    logic [7:0]              cur_angle_reg, cur_angle_next;
    logic [7:0]              start_deg_reg, start_deg_next;
    logic [TGT_W-1:0]        target_reg, target_next;
    logic [TIME_BITS-1:0]    elapsed_reg, elapsed_next;
    logic [TIME_BITS-1:0]    length_reg, length_next;
    logic                    ease_on_reg, ease_on_next;
    logic [7:0]              deg_reg, deg_next;
    logic                    pv_reg, pv_next;
    logic                    oor_reg, oor_next;
    logic [PULSE_BITS-1:0]   pulse_reg, pulse_next;

    // move request decode
    logic signed [CL_W-1:0]  req_ext;
    logic signed [CL_W-1:0]  full_cl;
    logic [TGT_W-1:0]        full_tgt;
    logic [TGT_W-1:0]        home_fx;
    logic [TGT_W-1:0]        move_tgt;
    logic                    move_oor;
    logic [TIME_BITS-1:0]    dur_t;
    logic [TIME_BITS-1:0]    elapsed_inc;

    // ease arithmetic
    logic [TGT_W-1:0]        start_fx;
    logic                    delta_neg;
    logic [TGT_W-1:0]        abs_delta;
    logic [VAL_W-1:0]        base_val;
    logic [VAL_W-1:0]        mag_val;
    logic [VAL_W-1:0]        eased_val;

    // pulse arithmetic
    logic [SPAN_W-1:0]       span_s;
    logic                    span_neg;
    logic [PULSE_BITS-1:0]   span_abs;
    logic [PROD_W-1:0]       prod_abs;
    logic [PULSE_BITS-1:0]   quo_p;
    logic [PULSE_BITS-1:0]   pulse_calc;

    // serial unit hookup
    logic                    xdiv_start, xdiv_done;
    logic [XQ_BITS-1:0]      xq;
    logic                    pdiv_start, pdiv_done;
    logic [PROD_W-1:0]       pdiv_quo;
    logic                    mul_start, mul_done;
    logic [MUL_A_W-1:0]      mul_a;
    logic [MUL_B_W-1:0]      mul_b;
    logic [MUL_P_W-1:0]      mul_p;

    // ease fraction x = elapsed * 2^16 / length
    sem_sdiv #(
        .DEN_W (TIME_BITS),
        .STEPS (XQ_BITS)
    ) u_xdiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (xdiv_start),
        .rem_init (elapsed_inc),
        .num      ('0),
        .den      (length_reg),
        .done     (xdiv_done),
        .quo      (xq)
    );

    // pulse offset |deg * span| / 180
    sem_sdiv #(
        .DEN_W (ANGLE_INT_W),
        .STEPS (PROD_W)
    ) u_pdiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (pdiv_start),
        .rem_init ('0),
        .num      (prod_abs),
        .den      (ANGLE_INT_W'(FULL_DEG)),
        .done     (pdiv_done),
        .quo      (pdiv_quo)
    );

    // shared multiplier: x*x, x2*(3-2x), |delta|*s
    sem_smul #(
        .A_W (MUL_A_W),
        .B_W (MUL_B_W)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .p     (mul_p)
    );

    // clamp the requested angle into 0..180 degrees
    always_comb
    begin
        req_ext  = {{(CL_W-17){target_angle[16]}}, target_angle};
        full_cl  = CL_W'(FULL_DEG) << ANGLE_FRAC_BITS;
        full_tgt = TGT_W'(FULL_DEG) << ANGLE_FRAC_BITS;
        home_fx  = TGT_W'(default_angle) << ANGLE_FRAC_BITS;
        move_oor = 1'b0;
        move_tgt = home_fx;
        if (op == OP_MOVE)
        begin
            if (req_ext[CL_W-1])
            begin
                move_oor = 1'b1;
                move_tgt = '0;
            end
            else if (req_ext > full_cl)
            begin
                move_oor = 1'b1;
                move_tgt = full_tgt;
            end
            else
            begin
                move_tgt = TGT_W'(req_ext);
            end
        end
        else if (default_angle > 8'(FULL_DEG))
        begin
            move_oor = 1'b1;
            move_tgt = full_tgt;
        end
        dur_t       = TIME_BITS'(duration_ms);
        elapsed_inc = elapsed_reg + TIME_BITS'(1);
    end

    // eased angle start*2^(F+16) +/- |delta|*s, floored to whole degrees
    always_comb
    begin
        start_fx  = TGT_W'(start_deg_reg) << ANGLE_FRAC_BITS;
        delta_neg = (target_reg < start_fx);
        abs_delta = delta_neg ? (start_fx - target_reg) : (target_reg - start_fx);
        base_val  = VAL_W'(start_deg_reg) << VAL_SH;
        mag_val   = VAL_W'(mul_p);
        if (!delta_neg)
            eased_val = base_val + mag_val;
        else if (mag_val > base_val)
            eased_val = '0;
        else
            eased_val = base_val - mag_val;
    end

    // pulse = min + (deg * (max - min)) / 180, truncated toward zero
    always_comb
    begin
        span_s     = {1'b0, pulse_hi} - {1'b0, pulse_lo};
        span_neg   = span_s[SPAN_W-1];
        span_abs   = span_neg ? (pulse_lo - pulse_hi) : (pulse_hi - pulse_lo);
        prod_abs   = PROD_W'(deg_reg) * PROD_W'(span_abs);
        quo_p      = PULSE_BITS'(pdiv_quo);
        pulse_calc = span_neg ? (pulse_lo - quo_p) : (pulse_lo + quo_p);
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        cur_angle_next = cur_angle_reg;
        start_deg_next = start_deg_reg;
        target_next    = target_reg;
        elapsed_next   = elapsed_reg;
        length_next    = length_reg;
        ease_on_next   = ease_on_reg;
        deg_next       = deg_reg;
        pv_next        = pv_reg;
        oor_next       = oor_reg;
        pulse_next     = pulse_reg;
        xdiv_start     = 1'b0;
        pdiv_start     = 1'b0;
        mul_start      = 1'b0;
        mul_a          = '0;
        mul_b          = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    pv_next    = 1'b0;
                    oor_next   = 1'b0;
                    pulse_next = '0;
                    state_next = ST_DONE;
                    case (op)
                        OP_MOVE, OP_HOME:
                        begin
                            oor_next = move_oor;
                            if (dur_t == '0)
                            begin
                                deg_next     = 8'(move_tgt >> ANGLE_FRAC_BITS);
                                ease_on_next = 1'b0;
                                pv_next      = 1'b1;
                                state_next   = ST_APPLY;
                            end
                            else
                            begin
                                start_deg_next = cur_angle_reg;
                                target_next    = move_tgt;
                                elapsed_next   = '0;
                                length_next    = dur_t;
                                ease_on_next   = 1'b1;
                            end
                        end
                        OP_TICK:
                        begin
                            if (ease_on_reg)
                            begin
                                elapsed_next = elapsed_inc;
                                pv_next      = 1'b1;
                                if (elapsed_inc >= length_reg)
                                begin
                                    deg_next     = 8'(target_reg >> ANGLE_FRAC_BITS);
                                    ease_on_next = 1'b0;
                                    state_next   = ST_APPLY;
                                end
                                else
                                begin
                                    xdiv_start = 1'b1;
                                    state_next = ST_DIVX;
                                end
                            end
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_DIVX:
            begin
                if (xdiv_done)
                begin
                    mul_start  = 1'b1;
                    mul_a      = MUL_A_W'(xq);
                    mul_b      = MUL_B_W'(xq);
                    state_next = ST_SQ;
                end
            end
            ST_SQ:
            begin
                // x2 = x*x / 2^16, then x2 * (3 - 2x); x still held in the divider
                if (mul_done)
                begin
                    mul_start  = 1'b1;
                    mul_a      = MUL_A_W'(mul_p[2*XQ_BITS-1:XQ_BITS]);
                    mul_b      = MUL_B_W'(SMOOTH_K) - MUL_B_W'({xq, 1'b0});
                    state_next = ST_SS;
                end
            end
            ST_SS:
            begin
                if (mul_done)
                begin
                    mul_start  = 1'b1;
                    mul_a      = MUL_A_W'(abs_delta);
                    mul_b      = MUL_B_W'(mul_p[2*XQ_BITS:XQ_BITS]);
                    state_next = ST_SV;
                end
            end
            ST_SV:
            begin
                if (mul_done)
                begin
                    deg_next   = 8'(eased_val >> VAL_SH);
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                pdiv_start = 1'b1;
                state_next = ST_DIVP;
            end
            ST_DIVP:
            begin
                if (pdiv_done)
                begin
                    pulse_next     = pulse_calc;
                    cur_angle_next = deg_reg;
                    state_next     = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (res_ready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and servo state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cur_angle_reg <= 8'(DEFAULT_ANGLE_RST);
            start_deg_reg <= '0;
            target_reg    <= '0;
            elapsed_reg   <= '0;
            length_reg    <= '0;
            ease_on_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_angle_reg <= cur_angle_next;
            start_deg_reg <= start_deg_next;
            target_reg    <= target_next;
            elapsed_reg   <= elapsed_next;
            length_reg    <= length_next;
            ease_on_reg   <= ease_on_next;
        end
    end

    // per-word working values
    always_ff @(posedge clk)
    begin
        deg_reg   <= deg_next;
        pv_reg    <= pv_next;
        oor_reg   <= oor_next;
        pulse_reg <= pulse_next;
    end

    assign in_ready   = (state_reg == ST_IDLE);
    assign res_valid  = (state_reg == ST_DONE);
    assign res_status = '{pulse_valid: pv_reg, out_of_range: oor_reg,
                          easing_active: ease_on_reg};
    assign res_pulse  = pulse_reg;
    assign res_angle  = cur_angle_reg;

    // an active ease never reaches its end without being retired
    assert property (@(posedge clk) disable iff (!rst_n)
        ease_on_reg |-> (elapsed_reg < length_reg))
        else $error("ease active with elapsed at or past its length");

    // the stored angle stays within travel
    assert property (@(posedge clk) disable iff (!rst_n)
        cur_angle_reg <= 8'(FULL_DEG))
        else $error("stored angle beyond 180 degrees");

    // a word without a new pulse carries a zero width
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !pv_reg) |-> (pulse_reg == '0))
        else $error("pulse width nonzero on a word without a pulse");

    // an accepted word always leaves idle on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg != ST_IDLE))
        else $error("accepted word dropped by the sequencer");

endmodule
